// File: hw/rtl/pse_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the postfix stack evaluator
// no dependencies; imported by every module of the block

package pse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_MALFORMED = 2'd1;
   localparam logic [1:0] ERR_DIV_ZERO  = 2'd2;

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_PLUS  = 2'd1;
   localparam logic [1:0] PEND_MINUS = 2'd2;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic              div_zero;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_code;
   } req_beat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [1:0]               error_code;
   } rsp_beat_type;

endpackage

// File: hw/rtl/pse_stack_ram.sv
`timescale 1ns / 1ps
// operand stack storage: one write port, one registered read port
// depends on pse_pkg for depth and widths

module pse_stack_ram import pse_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] stack_mem_ff [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pse_alu.sv
`timescale 1ns / 1ps
// shared arithmetic unit: add, subtract and multiply in a single step,
// signed divide by a radix-2 restoring loop; depends on pse_pkg

module pse_alu import pse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   localparam int STEP_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              dz_ff, dz_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W+1:0] trial;
   logic              qbit;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      dz_in     = dz_ff;
      result_in = result_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      trial     = {1'b0, rem_ff, quo_ff[DATA_W-1]} - {2'b00, dvs_ff};
      qbit      = ~trial[DATA_W+1];

      if (busy_ff) begin
         // one quotient bit per cycle
         rem_in = qbit ? trial[DATA_W-1:0] : {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
         quo_in = {quo_ff[DATA_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            dz_in     = 1'b0;
            result_in = neg_ff ? (~quo_in + 1'b1) : quo_in;
         end
      end else if (req.start) begin
         case (req.op)
            ALU_ADD: begin
               done_in   = 1'b1;
               dz_in     = 1'b0;
               result_in = req.left + req.right;
            end
            ALU_SUB: begin
               done_in   = 1'b1;
               dz_in     = 1'b0;
               result_in = req.left - req.right;
            end
            ALU_MUL: begin
               done_in   = 1'b1;
               dz_in     = 1'b0;
               result_in = req.left * req.right;
            end
            ALU_DIV: begin
               if (req.right == '0) begin
                  done_in = 1'b1;
                  dz_in   = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  cnt_in  = STEP_W'(DATA_W - 1);
                  rem_in  = '0;
                  quo_in  = req.left[DATA_W-1] ? (~req.left + 1'b1) : req.left;
                  dvs_in  = req.right[DATA_W-1] ? (~req.right + 1'b1) : req.right;
                  neg_in  = req.left[DATA_W-1] ^ req.right[DATA_W-1];
               end
            end
            default: begin
               done_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dz_ff     <= dz_in;
      result_ff <= result_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.div_zero = dz_ff;
   assign rsp.result   = result_ff;

endmodule

// File: hw/rtl/postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps
// postfix expression evaluator top level: sequencer, stack and result register
// depends on pse_pkg, pse_alu and pse_stack_ram

// One character beat per item, closed by an end beat that returns one result
// (value, or error 1 for malformed/overflow, 2 for division by zero). The block
// handles one beat at a time: a space, digit or sign is decoded in the dispatch
// state; ending a number adds a stack push; any other token pushes zero; '*'
// reads two stack entries, runs the shared unit and pushes the result, as does
// the beat after a '+' or '-' that turns out to be an operator; '/' does the
// same with the divider producing one quotient bit per cycle. The end beat
// runs any pending push or operator first, and waits while an earlier result is
// still unclaimed. The result waits in an output register, so characters of
// the next expression are taken while it is unclaimed. No clearing pass follows
// reset.

module postfix_stack_evaluator_unit import pse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_data
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DISPATCH = 7'b0000010,
      ST_RD_RIGHT = 7'b0000100,
      ST_EXEC     = 7'b0001000,
      ST_WAIT     = 7'b0010000,
      ST_PUSH     = 7'b0100000,
      ST_OUT      = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [7:0]        char_ff, char_in;
   logic              consumed_ff, consumed_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              in_num_ff, in_num_in;
   logic              neg_ff, neg_in;
   logic [1:0]        pend_ff, pend_in;
   logic [1:0]        err_ff, err_in;
   alu_op_type        op_ff, op_in;
   logic [DATA_W-1:0] right_ff, right_in;
   logic [DATA_W-1:0] push_val_ff, push_val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_beat_type      rsp_data_ff, rsp_data_in;

   logic              is_digit;
   logic [DATA_W-1:0] digit_val;
   logic [DATA_W-1:0] acc_next;
   logic              slot_free;
   logic              op_go;
   alu_op_type        op_sel;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   pse_stack_ram u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (push_val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pse_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign is_digit  = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign digit_val = DATA_W'(char_ff - CHAR_ZERO);
   // times ten as two shifted adds
   assign acc_next  = (acc_ff << 3) + (acc_ff << 1) + digit_val;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      consumed_in  = consumed_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      in_num_in    = in_num_ff;
      neg_in       = neg_ff;
      pend_in      = pend_ff;
      err_in       = err_ff;
      op_in        = op_ff;
      right_in     = right_ff;
      push_val_in  = push_val_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      op_go        = 1'b0;
      op_sel       = ALU_ADD;
      wr_en        = 1'b0;
      rd_addr      = '0;
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;
      alu_req.left  = rd_data;
      alu_req.right = right_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in     = req_data.kind;
               char_in     = req_data.char_code;
               consumed_in = 1'b0;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (kind_ff == KIND_CHAR) begin
               if (err_ff != ERR_OK || consumed_ff) begin
                  state_in = ST_IDLE;
               end else if (pend_ff != PEND_NONE) begin
                  pend_in = PEND_NONE;
                  if (is_digit) begin
                     in_num_in = 1'b1;
                     neg_in    = (pend_ff == PEND_MINUS);
                     acc_in    = digit_val;
                     state_in  = ST_IDLE;
                  end else begin
                     op_go  = 1'b1;
                     op_sel = (pend_ff == PEND_MINUS) ? ALU_SUB : ALU_ADD;
                  end
               end else if (in_num_ff) begin
                  if (is_digit) begin
                     acc_in   = acc_next;
                     state_in = ST_IDLE;
                  end else begin
                     push_val_in = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
                     in_num_in   = 1'b0;
                     neg_in      = 1'b0;
                     acc_in      = '0;
                     state_in    = ST_PUSH;
                  end
               end else begin
                  consumed_in = 1'b1;
                  state_in    = ST_IDLE;
                  if (is_digit) begin
                     in_num_in = 1'b1;
                     neg_in    = 1'b0;
                     acc_in    = digit_val;
                  end else if (char_ff == CHAR_SPACE) begin
                     state_in = ST_IDLE;
                  end else if (char_ff == CHAR_PLUS) begin
                     pend_in = PEND_PLUS;
                  end else if (char_ff == CHAR_MINUS) begin
                     pend_in = PEND_MINUS;
                  end else if (char_ff == CHAR_STAR) begin
                     op_go  = 1'b1;
                     op_sel = ALU_MUL;
                  end else if (char_ff == CHAR_SLASH) begin
                     op_go  = 1'b1;
                     op_sel = ALU_DIV;
                  end else begin
                     // any other character is a token worth zero
                     push_val_in = '0;
                     state_in    = ST_PUSH;
                  end
               end
            end else begin
               if (err_ff != ERR_OK) begin
                  state_in = ST_OUT;
               end else if (in_num_ff) begin
                  push_val_in = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
                  in_num_in   = 1'b0;
                  neg_in      = 1'b0;
                  acc_in      = '0;
                  state_in    = ST_PUSH;
               end else if (pend_ff != PEND_NONE) begin
                  pend_in = PEND_NONE;
                  op_go   = 1'b1;
                  op_sel  = (pend_ff == PEND_MINUS) ? ALU_SUB : ALU_ADD;
               end else begin
                  // bottom entry is read here and held through the output state
                  if (count_ff != CNT_W'(1)) begin
                     err_in = ERR_MALFORMED;
                  end
                  state_in = ST_OUT;
               end
            end
         end
         ST_RD_RIGHT: begin
            right_in = rd_data;
            rd_addr  = ADDR_W'(count_ff - CNT_W'(2));
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            alu_req.start = 1'b1;
            count_in      = count_ff - CNT_W'(2);
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (alu_rsp.done) begin
               if (alu_rsp.div_zero) begin
                  err_in   = ERR_DIV_ZERO;
                  state_in = ST_DISPATCH;
               end else begin
                  push_val_in = alu_rsp.result;
                  state_in    = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if (count_ff == CNT_W'(STACK_DEPTH)) begin
               err_in = ERR_MALFORMED;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_DISPATCH;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.value      = (err_ff == ERR_OK) ? rd_data : '0;
               rsp_data_in.error_code = err_ff;
               count_in               = '0;
               acc_in                 = '0;
               in_num_in              = 1'b0;
               neg_in                 = 1'b0;
               pend_in                = PEND_NONE;
               err_in                 = ERR_OK;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (op_go) begin
         if (count_ff < CNT_W'(2)) begin
            err_in   = ERR_MALFORMED;
            state_in = ST_DISPATCH;
         end else begin
            op_in    = op_sel;
            rd_addr  = ADDR_W'(count_ff - CNT_W'(1));
            state_in = ST_RD_RIGHT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         acc_ff       <= '0;
         in_num_ff    <= 1'b0;
         neg_ff       <= 1'b0;
         pend_ff      <= PEND_NONE;
         err_ff       <= ERR_OK;
         consumed_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         in_num_ff    <= in_num_in;
         neg_ff       <= neg_in;
         pend_ff      <= pend_in;
         err_ff       <= err_in;
         consumed_ff  <= consumed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      char_ff     <= char_in;
      op_ff       <= op_in;
      right_ff    <= right_in;
      push_val_ff <= push_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_alu_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> state_ff == ST_WAIT)
      else $error("arithmetic unit finished outside the wait state");

   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.error_code != ERR_OK |-> rsp_data_ff.value == '0)
      else $error("error result carries a nonzero value");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && slot_free |=>
         count_ff == '0 && err_ff == ERR_OK && pend_ff == PEND_NONE && !in_num_ff
         && rsp_valid_ff)
      else $error("expression state not cleared after end beat");

endmodule

// File: verif/postfix_stack_evaluator_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for postfix_stack_evaluator_unit: random and corner rpn text
// depends on pse_pkg and the evaluator rtl; a local rpn evaluator predicts each end beat

module postfix_stack_evaluator_unit_tb;
   import pse_pkg::*;

   typedef struct packed {
      logic         hold;
      req_beat_type beat;
   } send_slot_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;

   send_slot_type send_queue[$];
   rsp_beat_type  awaited_results[$];
   int unsigned   error_count  = 0;
   int unsigned   beats_queued = 0;
   int unsigned   send_gap     = 0;
   int unsigned   send_burst   = 0;
   int unsigned   stall_left   = 0;
   int unsigned   calm_left    = 0;

   // evaluator state
   logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
   int unsigned       eval_depth;
   logic [DATA_W-1:0] digit_acc;
   bit                in_digits;
   bit                digits_negative;
   logic [1:0]        sign_held;
   logic [1:0]        error_held;

   postfix_stack_evaluator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic void clear_expression();
      eval_depth      = 0;
      digit_acc       = '0;
      in_digits       = 1'b0;
      digits_negative = 1'b0;
      sign_held       = PEND_NONE;
      error_held      = ERR_OK;
   endfunction

   function automatic void push_operand(logic [DATA_W-1:0] v);
      if (eval_depth >= STACK_DEPTH) begin
         error_held = ERR_MALFORMED;
         return;
      end
      eval_stack[eval_depth] = v;
      eval_depth++;
   endfunction

   function automatic void apply_operator(logic [7:0] op);
      logic [DATA_W-1:0] lhs, rhs, res, mag_l, mag_r;
      if (eval_depth < 2) begin
         error_held = ERR_MALFORMED;
         return;
      end
      rhs = eval_stack[eval_depth-1];
      lhs = eval_stack[eval_depth-2];
      eval_depth -= 2;
      case (op)
         CHAR_PLUS:  res = lhs + rhs;
         CHAR_MINUS: res = lhs - rhs;
         CHAR_STAR:  res = lhs * rhs;
         default: begin
            if (rhs == '0) begin
               error_held = ERR_DIV_ZERO;
               return;
            end
            // divide magnitudes, then restore the sign (truncates toward zero)
            mag_l = lhs[DATA_W-1] ? -lhs : lhs;
            mag_r = rhs[DATA_W-1] ? -rhs : rhs;
            res   = mag_l / mag_r;
            if (lhs[DATA_W-1] ^ rhs[DATA_W-1])
               res = -res;
         end
      endcase
      push_operand(res);
   endfunction

   function automatic void close_number();
      logic [DATA_W-1:0] v;
      v = digits_negative ? -digit_acc : digit_acc;
      in_digits       = 1'b0;
      digits_negative = 1'b0;
      digit_acc       = '0;
      push_operand(v);
   endfunction

   function automatic void feed_char(logic [7:0] c);
      logic [7:0] op;
      if (sign_held != PEND_NONE) begin
         op        = (sign_held == PEND_MINUS) ? CHAR_MINUS : CHAR_PLUS;
         sign_held = PEND_NONE;
         // a sign directly followed by a digit starts a signed number
         if (is_digit(c)) begin
            in_digits       = 1'b1;
            digits_negative = (op == CHAR_MINUS);
            digit_acc       = DATA_W'(c - CHAR_ZERO);
            return;
         end
         apply_operator(op);
         if (error_held != ERR_OK)
            return;
      end
      if (in_digits) begin
         if (is_digit(c)) begin
            digit_acc = digit_acc * 32'd10 + DATA_W'(c - CHAR_ZERO);
            return;
         end
         close_number();
         if (error_held != ERR_OK)
            return;
      end
      if (c == CHAR_SPACE)
         return;
      if (is_digit(c)) begin
         in_digits       = 1'b1;
         digits_negative = 1'b0;
         digit_acc       = DATA_W'(c - CHAR_ZERO);
      end else if (c == CHAR_PLUS) begin
         sign_held = PEND_PLUS;
      end else if (c == CHAR_MINUS) begin
         sign_held = PEND_MINUS;
      end else if (c == CHAR_STAR || c == CHAR_SLASH) begin
         apply_operator(c);
      end else begin
         push_operand('0);
      end
   endfunction

   function automatic void evaluate_beat(req_beat_type b);
      rsp_beat_type r;
      if (b.kind == KIND_CHAR) begin
         if (error_held == ERR_OK)
            feed_char(b.char_code);
         return;
      end
      if (error_held == ERR_OK && in_digits)
         close_number();
      if (error_held == ERR_OK && sign_held != PEND_NONE) begin
         // trailing sign is an operator
         apply_operator((sign_held == PEND_MINUS) ? CHAR_MINUS : CHAR_PLUS);
         sign_held = PEND_NONE;
      end
      if (error_held == ERR_OK && eval_depth != 1)
         error_held = ERR_MALFORMED;
      r.error_code = error_held;
      r.value      = (error_held == ERR_OK) ? eval_stack[0] : '0;
      awaited_results.push_back(r);
      clear_expression();
   endfunction

   task automatic put_beat(logic hold, logic kind, logic [7:0] c);
      send_slot_type s;
      s.hold           = hold;
      s.beat.kind      = kind;
      s.beat.char_code = c;
      send_queue.push_back(s);
      if (!hold)
         beats_queued++;
   endtask

   task automatic put_char(logic [7:0] c);
      put_beat(1'b0, KIND_CHAR, c);
   endtask

   task automatic put_end();
      put_beat(1'b0, KIND_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++)
         put_char(s[i]);
   endtask

   task automatic put_sep();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         put_char(CHAR_SPACE);
      else if (roll < 90)
         put_text("  ");
   endtask

   task automatic put_number();
      int unsigned roll, n;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         // random character: most often an odd one that pushes zero
         put_char(8'($urandom_range(0, 255)));
         return;
      end
      if (roll < 22)
         put_char(CHAR_MINUS);
      else if (roll < 30)
         put_char(CHAR_PLUS);
      roll = $urandom_range(0, 99);
      if (roll < 60)
         n = 1;
      else if (roll < 85)
         n = $urandom_range(2, 4);
      else if (roll < 97)
         n = $urandom_range(5, 10);
      else
         n = $urandom_range(11, 14);
      repeat (n) put_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic put_operator();
      case ($urandom_range(0, 3))
         0:       put_char(CHAR_PLUS);
         1:       put_char(CHAR_MINUS);
         2:       put_char(CHAR_STAR);
         default: put_char(CHAR_SLASH);
      endcase
   endtask

   task automatic put_rpn(int unsigned operands);
      int unsigned depth, left;
      depth = 0;
      left  = operands;
      while (left > 0 || depth > 1) begin
         if (left > 0 && (depth < 2 || $urandom_range(0, 1))) begin
            put_number();
            depth++;
            left--;
         end else begin
            put_operator();
            depth--;
         end
         put_sep();
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2)
         send_burst = $urandom_range(20, 100);
      if (roll < 50)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // sender: one beat at a time from send_queue
   always @(posedge clock) begin
      bit taken;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken)
            evaluate_beat(req_data);
         if (req_valid && !taken) begin
            // stalled beat holds
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (send_queue.size() > 0 && !send_queue[0].hold) begin
            req_valid <= 1'b1;
            req_data  <= send_queue[0].beat;
            void'(send_queue.pop_front());
            send_gap = pick_gap();
         end else begin
            // hold marker gives way once every result is in
            if (send_queue.size() > 0 && awaited_results.size() == 0)
               void'(send_queue.pop_front());
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: checks each result beat and stalls at random
   always @(posedge clock) begin
      rsp_beat_type want;
      int unsigned  roll;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result beat: value %0d error_code %0d",
                      rsp_data.value, rsp_data.error_code);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_data.value);
                  error_count++;
               end
               if (rsp_data.error_code !== want.error_code) begin
                  $error("error_code: expected %0d, actual %0d",
                         want.error_code, rsp_data.error_code);
                  error_count++;
               end
            end
         end
         if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
               calm_left = $urandom_range(50, 200);
            else if (roll < 25)
               stall_left = $urandom_range(0, 3);
            else if (roll < 30)
               stall_left = $urandom_range(10, 60);
            rsp_stall <= (roll >= 2 && roll < 30);
         end
      end
   end

   initial begin
      int unsigned roll;
      clear_expression();

      // empty expression, end beat with all char bits set
      put_beat(1'b0, KIND_END, 8'hFF);
      // nul token alone
      put_char(8'h00);
      put_end();
      // 0xff and tab tokens multiplied
      put_char(8'hFF);
      put_char(8'h09);
      put_char(CHAR_STAR);
      put_end();
      // signed number after a value, trailing minus as operator
      put_text("99-1-");
      put_end();
      // underflow
      put_text("6+");
      put_end();
      // zero divisor
      put_text("5 0/");
      put_end();
      // two values left
      put_text("3 4");
      put_end();
      put_beat(1'b1, KIND_CHAR, 8'h00);

      // full stack, then one push too many
      for (int n = STACK_DEPTH; n <= STACK_DEPTH + 1; n++) begin
         repeat (n) put_text("1 ");
         repeat (n - 1) put_char(CHAR_PLUS);
         put_end();
      end

      while (beats_queued < 1950) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            put_rpn($urandom_range(1, 6));
         end else if (roll < 79) begin
            put_rpn($urandom_range(1, 4));
            put_operator();
         end else if (roll < 85) begin
            put_rpn($urandom_range(1, 3));
            put_sep();
            put_number();
         end else if (roll < 92) begin
            repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 7))
               0:       put_text("-2147483648 -1/");
               1:       put_text("2147483647 1+");
               2:       put_text("4294967297");
               3:       put_text("-7 2/");
               4:       put_text("7 -2/");
               5:       put_text("65536 65536*");
               6:       put_text("5 0 /");
               default: put_text("3 4-");
            endcase
         end
         put_end();
         if ($urandom_range(0, 99) < 3)
            put_beat(1'b1, KIND_CHAR, 8'h00);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sampled mid-cycle so the sender's updates have settled
      @(negedge clock);
      while (send_queue.size() > 0 || req_valid || awaited_results.size() > 0)
         @(negedge clock);
      repeat (100) @(posedge clock);

      if (error_count == 0)
         $display("postfix_stack_evaluator_unit regression: pass");
      else
         $display("postfix_stack_evaluator_unit regression: fail");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("postfix_stack_evaluator_unit regression: fail");
      $finish;
   end

endmodule
